// ===== rtl/sspq_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package sspq_pkg;

    localparam int CAPACITY = 16;
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    localparam int WORD_W   = 32;
    localparam int OCC_W    = 5;
    localparam int S_DATA_W = 64;
    localparam int M_DATA_W = 40;

    // command codes
    localparam logic CMD_ENQ = 1'b0;
    localparam logic CMD_DEQ = 1'b1;

    // status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    typedef struct packed {
        logic [WORD_W-1:0] value;
        logic [WORD_W-1:0] rank;
    } sspq_entry_t;

    typedef struct packed {
        logic enq;   // insert the new entry this cycle
        logic deq;   // pop the front entry this cycle
    } sspq_op_t;

endpackage

`default_nettype wire

// ===== rtl/sspq_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none

module sspq_cell (
    input  wire                  aclk,
    input  sspq_pkg::sspq_op_t   op,
    input  sspq_pkg::sspq_entry_t new_entry,
    input  wire                  occupied,
    input  wire                  prev_le,
    input  sspq_pkg::sspq_entry_t left_entry,
    input  sspq_pkg::sspq_entry_t right_entry,
    output sspq_pkg::sspq_entry_t entry,
    output logic                 le
);
    import sspq_pkg::*;

    sspq_entry_t entry_reg;

    // held entry ranks at or below the new one: it stays ahead of the new entry
    assign le    = occupied && ($signed(entry_reg.rank) <= $signed(new_entry.rank));
    assign entry = entry_reg;

    always_ff @(posedge aclk) begin
        if (op.enq) begin
            if (!le) begin
                // first cell behind the insertion point takes the new entry
                if (prev_le) begin
                    entry_reg <= new_entry;
                end else begin
                    entry_reg <= left_entry;
                end
            end
        end else if (op.deq) begin
            entry_reg <= right_entry;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/stable_sorted_priority_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Channel  Dir  tdata (low bit up)                      tuser
// s_       in   item_value[31:0], rank[63:32]           command (0 enq, 1 deq)
// m_       out  out_value[31:0], occupancy[36:32]       status (0 ok, 1 empty, 2 full)
//
// One item per cycle while s_tready is high: every cell of the chain compares its rank
// with the new one and shifts in parallel, so the whole row updates on the accepting edge.
// The result appears in the output register in the cycle after acceptance.
// Reset clears the entry count and the output valid; cell contents are left.
// s_tready drops only while a result waits in the output register unread.

module stable_sorted_priority_queue (
    input  wire                             aclk,
    input  wire                             aresetn,
    input  wire                             s_tvalid,
    output logic                            s_tready,
    input  wire  [sspq_pkg::S_DATA_W-1:0]   s_tdata,   // item_value, rank
    input  wire                             s_tuser,   // command
    output logic                            m_tvalid,
    input  wire                             m_tready,
    output logic [sspq_pkg::M_DATA_W-1:0]   m_tdata,   // out_value, occupancy, zero pad
    output logic [1:0]                      m_tuser    // status
);
    import sspq_pkg::*;

    logic [CNT_W-1:0]    count_reg, count_next;
    logic                m_tvalid_reg;
    logic [M_DATA_W-1:0] m_tdata_reg, m_tdata_next;
    logic [1:0]          m_tuser_reg, m_tuser_next;

    logic        accept;
    logic        full, empty;
    sspq_op_t    op;
    sspq_entry_t new_entry;
    sspq_entry_t cell_entry [CAPACITY];
    logic        cell_le    [CAPACITY];

    assign s_tready = !m_tvalid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;
    assign full     = (count_reg == CNT_W'(CAPACITY));
    assign empty    = (count_reg == '0);

    assign new_entry.value = s_tdata[WORD_W-1:0];
    assign new_entry.rank  = s_tdata[2*WORD_W-1:WORD_W];

    assign op.enq = accept && (s_tuser == CMD_ENQ) && !full;
    assign op.deq = accept && (s_tuser == CMD_DEQ) && !empty;

    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        sspq_entry_t left_e, right_e;
        logic        prev_le;

        if (i == 0) begin : g_head
            assign left_e  = new_entry;
            assign prev_le = 1'b1;
        end else begin : g_mid
            assign left_e  = cell_entry[i-1];
            assign prev_le = cell_le[i-1];
        end

        if (i == CAPACITY - 1) begin : g_tail
            assign right_e = '0;
        end else begin : g_body
            assign right_e = cell_entry[i+1];
        end

        sspq_cell u_cell (
            .aclk        (aclk),
            .op          (op),
            .new_entry   (new_entry),
            .occupied    (count_reg > CNT_W'(i)),
            .prev_le     (prev_le),
            .left_entry  (left_e),
            .right_entry (right_e),
            .entry       (cell_entry[i]),
            .le          (cell_le[i])
        );
    end

    always_comb begin
        count_next   = count_reg;
        m_tuser_next = ST_OK;
        m_tdata_next = '0;
        if (op.enq) begin
            count_next = count_reg + CNT_W'(1);
        end else if (op.deq) begin
            count_next = count_reg - CNT_W'(1);
            m_tdata_next[WORD_W-1:0] = cell_entry[0].value;
        end else if (s_tuser == CMD_ENQ) begin
            m_tuser_next = ST_FULL;
        end else begin
            m_tuser_next = ST_EMPTY;
        end
        m_tdata_next[WORD_W+OCC_W-1:WORD_W] = OCC_W'(count_next);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (accept) begin
                count_reg    <= count_next;
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            m_tdata_reg <= m_tdata_next;
            m_tuser_reg <= m_tuser_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(CAPACITY))
        else $error("entry count beyond capacity");

    a_enq_grows: assert property (@(posedge aclk) disable iff (!aresetn)
        op.enq |=> count_reg == $past(count_reg) + CNT_W'(1))
        else $error("enqueue did not add an entry");

    a_empty_status: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && (s_tuser == CMD_DEQ) && empty |=> m_tvalid && (m_tuser == ST_EMPTY))
        else $error("dequeue from empty queue not flagged");

    a_full_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && (s_tuser == CMD_ENQ) && full |=> m_tuser == ST_FULL && full)
        else $error("enqueue into full queue changed state");

endmodule

`default_nettype wire
